// File: rtl/core/tpim_pkg.sv
`timescale 1ns / 1ps

package tpim_pkg;

  localparam int unsigned MAX_DIMS_DEF   = 4;
  localparam int unsigned INDEX_BITS_DEF = 20;
  localparam int unsigned REG_DIMS       = 4;
  localparam int unsigned EXT_W          = 11;
  localparam int unsigned AXIS_W         = 2;
  localparam int unsigned DIMC_W         = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 11;

  typedef logic [EXT_W-1:0] ext_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT  = 3'd0,
    CFG_EXTENT_0   = 3'd1,
    CFG_EXTENT_1   = 3'd2,
    CFG_EXTENT_2   = 3'd3,
    CFG_EXTENT_3   = 3'd4,
    CFG_AXIS_ORDER = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    ext_t [REG_DIMS-1:0] crd;
    logic                oor;
  } pass_t;

endpackage

// File: rtl/core/tpim_div_bit.sv
`timescale 1ns / 1ps

module tpim_div_bit #(
  parameter int unsigned IB = tpim_pkg::INDEX_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [IB-1:0]        num_i,
  input  tpim_pkg::ext_t       rem_i,
  input  tpim_pkg::ext_t       divisor_i,
  input  tpim_pkg::pass_t      pass_i,
  output logic                 valid_o,
  output logic [IB-1:0]        num_o,
  output tpim_pkg::ext_t       rem_o,
  output tpim_pkg::pass_t      pass_o
);
  import tpim_pkg::*;

  logic [EXT_W:0]  trial;
  logic            take;
  ext_t            rem_d;
  logic [IB-1:0]   num_d;
  logic            valid_q;
  logic [IB-1:0]   num_q;
  ext_t            rem_q;
  pass_t           pass_q;

  always_comb begin
    trial = {rem_i, num_i[IB-1]};
    take  = trial >= {1'b0, divisor_i};
    rem_d = take ? EXT_W'(trial - {1'b0, divisor_i}) : EXT_W'(trial);
    num_d = {num_i[IB-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign pass_o  = pass_q;

endmodule

// File: rtl/core/tpim_mac.sv
`timescale 1ns / 1ps

module tpim_mac #(
  parameter int unsigned IB   = tpim_pkg::INDEX_BITS_DEF,
  parameter int unsigned KIDX = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic [tpim_pkg::DIMC_W-1:0]            dims_i,
  input  logic [tpim_pkg::REG_DIMS*tpim_pkg::AXIS_W-1:0] axis_i,
  input  tpim_pkg::ext_t [tpim_pkg::REG_DIMS-1:0] ext_i,
  input  logic                                   valid_i,
  input  logic [IB-1:0]                          acc_i,
  input  tpim_pkg::pass_t                        pass_i,
  output logic                                   valid_o,
  output logic [IB-1:0]                          acc_o,
  output tpim_pkg::pass_t                        pass_o
);
  import tpim_pkg::*;

  logic [AXIS_W-1:0] ax;
  logic              use_ax;
  ext_t              mul_e;
  ext_t              add_c;
  logic              m_valid_q;
  logic [IB-1:0]     m_prod_q;
  ext_t              m_crd_q;
  pass_t             m_pass_q;
  logic              a_valid_q;
  logic [IB-1:0]     a_acc_q;
  pass_t             a_pass_q;

  always_comb begin
    ax     = axis_i[KIDX*AXIS_W +: AXIS_W];
    use_ax = (DIMC_W'(KIDX) < dims_i) && (DIMC_W'(ax) < dims_i);
    mul_e  = use_ax ? ext_i[ax] : EXT_W'(1);
    add_c  = use_ax ? pass_i.crd[ax] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      m_valid_q <= valid_i;
      a_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_prod_q <= IB'(acc_i * IB'(mul_e));
      m_crd_q  <= add_c;
      m_pass_q <= pass_i;
      a_acc_q  <= m_prod_q + IB'(m_crd_q);
      a_pass_q <= m_pass_q;
    end
  end

  assign valid_o = a_valid_q;
  assign acc_o   = a_acc_q;
  assign pass_o  = a_pass_q;

endmodule

// File: rtl/core/tensor_permute_index_map.sv
`timescale 1ns / 1ps
// Channel   Direction  Word
// s_axis    in         tdata: src_index
// m_axis    out        tdata: dst_index; tuser: out_of_range
// cfg       in         cfg_index_i selects the register, cfg_data_i carries the value
//
// One index is accepted every cycle while m_axis is not stalled. The pipeline has three
// restoring dividers of one quotient bit per stage, four two-stage multiply-add
// steps and the output register. Reset clears the valid bits and loads the
// register defaults. A stall at m_axis freezes the whole pipeline in place.
module tensor_permute_index_map #(
  parameter int unsigned MAX_DIMS   = tpim_pkg::MAX_DIMS_DEF,
  parameter int unsigned INDEX_BITS = tpim_pkg::INDEX_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // src_index
  input  logic [((INDEX_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // dst_index
  output logic [((INDEX_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // out_of_range
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tpim_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tpim_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import tpim_pkg::*;

  localparam int unsigned IB    = INDEX_BITS;
  localparam int unsigned DW    = ((INDEX_BITS+7)/8)*8;
  localparam int unsigned LIM   = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;
  localparam int unsigned NDIV  = REG_DIMS - 1;
  localparam int unsigned NS    = NDIV * IB;
  localparam int unsigned CW    = (IB > EXT_W) ? IB : EXT_W;

  logic [DIMC_W-1:0]                 dim_count_q;
  ext_t [REG_DIMS-1:0]               extent_q;
  logic [REG_DIMS*AXIS_W-1:0]        axis_q;
  logic [DIMC_W-1:0]                 dims;
  ext_t [REG_DIMS-1:0]               eff;
  logic                              en;

  logic                              dv   [NS+1];
  logic [IB-1:0]                     dnum [NS+1];
  ext_t                              drem [NS+1];
  pass_t                             dpas [NS+1];

  logic                              hv   [REG_DIMS+1];
  logic [IB-1:0]                     hacc [REG_DIMS+1];
  pass_t                             hpas [REG_DIMS+1];

  logic                              out_valid_q;
  logic [IB-1:0]                     out_dst_q;
  logic                              out_oor_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= DIMC_W'(4);
      extent_q    <= {REG_DIMS{EXT_W'(1)}};
      axis_q      <= 8'd228;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DIM_COUNT:  dim_count_q <= cfg_data_i[DIMC_W-1:0];
        CFG_EXTENT_0:   extent_q[0] <= cfg_data_i;
        CFG_EXTENT_1:   extent_q[1] <= cfg_data_i;
        CFG_EXTENT_2:   extent_q[2] <= cfg_data_i;
        CFG_EXTENT_3:   extent_q[3] <= cfg_data_i;
        CFG_AXIS_ORDER: axis_q      <= cfg_data_i[REG_DIMS*AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_count_q == '0) begin
      dims = DIMC_W'(1);
    end else if (dim_count_q > DIMC_W'(LIM)) begin
      dims = DIMC_W'(LIM);
    end else begin
      dims = dim_count_q;
    end
    for (int k = 0; k < REG_DIMS; k++) begin
      if (DIMC_W'(k) < dims && extent_q[k] != '0) begin
        eff[k] = extent_q[k];
      end else begin
        eff[k] = EXT_W'(1);
      end
    end
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign dv[0]   = s_axis_tvalid;
  assign dnum[0] = s_axis_tdata[IB-1:0];
  assign drem[0] = '0;
  assign dpas[0] = '0;

  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int unsigned G  = s / IB;
    localparam int unsigned B  = s % IB;
    localparam int unsigned CI = (G > 0) ? REG_DIMS - G : 0;
    ext_t  rem_in;
    pass_t pass_in;
    always_comb begin
      pass_in = dpas[s];
      rem_in  = drem[s];
      if (B == 0) begin
        rem_in = '0;
        if (G > 0) begin
          pass_in.crd[CI] = drem[s];
        end
      end
    end
    tpim_div_bit #(.IB(IB)) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (dv[s]),
      .num_i     (dnum[s]),
      .rem_i     (rem_in),
      .divisor_i (eff[REG_DIMS-1-G]),
      .pass_i    (pass_in),
      .valid_o   (dv[s+1]),
      .num_o     (dnum[s+1]),
      .rem_o     (drem[s+1]),
      .pass_o    (dpas[s+1])
    );
  end

  always_comb begin
    hpas[0]        = dpas[NS];
    hpas[0].crd[1] = drem[NS];
    hpas[0].crd[0] = EXT_W'(dnum[NS]);
    hpas[0].oor    = CW'(dnum[NS]) >= CW'(eff[0]);
  end
  assign hv[0]   = dv[NS];
  assign hacc[0] = '0;

  for (genvar k = 0; k < REG_DIMS; k++) begin : g_mac
    tpim_mac #(.IB(IB), .KIDX(k)) u_mac (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .dims_i  (dims),
      .axis_i  (axis_q),
      .ext_i   (eff),
      .valid_i (hv[k]),
      .acc_i   (hacc[k]),
      .pass_i  (hpas[k]),
      .valid_o (hv[k+1]),
      .acc_o   (hacc[k+1]),
      .pass_o  (hpas[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= hv[REG_DIMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_oor_q <= hpas[REG_DIMS].oor;
      out_dst_q <= hpas[REG_DIMS].oor ? '0 : hacc[REG_DIMS];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DW'(out_dst_q);
  assign m_axis_tuser  = out_oor_q;

endmodule

// File: rtl/core/tpim_chk.sv
`timescale 1ns / 1ps

module tpim_chk #(
  parameter int unsigned INDEX_BITS = tpim_pkg::INDEX_BITS_DEF
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [((INDEX_BITS+7)/8)*8-1:0]       m_axis_tdata,
  input logic                                  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out-of-range word carries a non-zero index");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_flow_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind tensor_permute_index_map tpim_chk #(.INDEX_BITS(INDEX_BITS)) u_tpim_chk (.*);

// File: tb/tensor_permute_index_map_tb.sv
`timescale 1ns / 1ps

module tensor_permute_index_map_tb;
  import tpim_pkg::*;

  localparam int unsigned IW = INDEX_BITS_DEF;
  localparam int unsigned DW = ((IW + 7) / 8) * 8;
  localparam int unsigned LATENCY = 3 * IW + 9;

  typedef struct packed {
    logic [IW-1:0] dst_index;
    logic          out_of_range;
  } perm_result_t;

  typedef struct {
    logic [IW-1:0] src;
    logic          known;
    perm_result_t  res;
  } stim_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [DW-1:0] m_axis_tdata;
  logic          m_axis_tuser;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [2:0]       dim_count_q;
  logic [EXT_W-1:0] extent_q [REG_DIMS];
  logic [7:0]       axis_order_q;

  perm_result_t pending_indices[$];
  int unsigned  error_count;
  bit           sender_done;

  tensor_permute_index_map DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint unsigned eff_extent(int unsigned i);
    return (extent_q[i] == '0) ? 1 : extent_q[i];
  endfunction

  function automatic perm_result_t permute_index(logic [IW-1:0] src);
    int unsigned       d;
    longint unsigned   total;
    longint unsigned   rest;
    longint unsigned   stride;
    longint unsigned   dst;
    longint unsigned   coord [REG_DIMS];
    int unsigned       a;
    perm_result_t      r;
    d = dim_count_q;
    if (d == 0) d = 1;
    if (d > MAX_DIMS_DEF) d = MAX_DIMS_DEF;
    total = 1;
    for (int i = 0; i < d; i++) total *= eff_extent(i);
    if (src >= total) begin
      r.dst_index = '0;
      r.out_of_range = 1'b1;
      return r;
    end
    rest = src;
    for (int k = d - 1; k >= 0; k--) begin
      coord[k] = rest % eff_extent(k);
      rest = rest / eff_extent(k);
    end
    stride = 1;
    dst = 0;
    for (int k = d - 1; k >= 0; k--) begin
      a = (axis_order_q >> (2 * k)) & 2'b11;
      if (a < d) begin
        dst += coord[a] * stride;
        stride *= eff_extent(a);
      end
    end
    r.dst_index = dst[IW-1:0];
    r.out_of_range = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("Mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DIM_COUNT:  dim_count_q <= value[2:0];
      CFG_AXIS_ORDER: axis_order_q <= value[7:0];
      default:        extent_q[idx - CFG_EXTENT_0] <= value;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_indices.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic configure_tensor(logic [2:0] dims, logic [10:0] e0, logic [10:0] e1,
                                  logic [10:0] e2, logic [10:0] e3, logic [7:0] order);
    drain_results();
    write_register(CFG_DIM_COUNT, dims);
    write_register(CFG_EXTENT_0, e0);
    write_register(CFG_EXTENT_1, e1);
    write_register(CFG_EXTENT_2, e2);
    write_register(CFG_EXTENT_3, e3);
    write_register(CFG_AXIS_ORDER, order);
    cfg_valid_i <= 1'b0;
  endtask

  // The expectation is queued at the handshake edge, so the predictor sees the
  // register values that the block holds for that word.
  task automatic send_index(logic [IW-1:0] src, logic known, perm_result_t want);
    perm_result_t r;
    int unsigned  gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DW'(src);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = permute_index(src);
    if (known && r != want) begin
      report_mismatch("directed table entry", r, want);
    end
    pending_indices = {pending_indices, r};
    @(negedge clk_i);
  endtask

  function automatic logic [IW-1:0] random_index();
    longint unsigned total;
    int unsigned     d;
    d = (dim_count_q == 0) ? 1 : (dim_count_q > 4 ? 4 : dim_count_q);
    total = 1;
    for (int i = 0; i < d; i++) total *= eff_extent(i);
    if ($urandom_range(0, 9) == 0 || total > (1 << IW)) return IW'($urandom);
    if ($urandom_range(0, 9) == 0) return IW'(total - 1);
    return IW'($urandom_range(0, int'(total - 1)));
  endfunction

  always @(posedge clk_i) begin
    perm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_indices.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 0);
      end else begin
        want = pending_indices.pop_front();
        if (m_axis_tdata[IW-1:0] !== want.dst_index)
          report_mismatch("dst_index", m_axis_tdata[IW-1:0], want.dst_index);
        if (m_axis_tuser !== want.out_of_range)
          report_mismatch("out_of_range", m_axis_tuser, want.out_of_range);
      end
    end
  end

  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sender_done || $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall = $urandom_range(0, 14);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
        while (!(m_axis_tvalid && m_axis_tready)) @(negedge clk_i);
      end
    end
  end

  stim_row_t directed_rows[] = '{
    '{20'd0,       1'b1, '{20'd0, 1'b0}},
    '{20'd1,       1'b1, '{20'd0, 1'b1}},
    '{20'hFFFFF,   1'b1, '{20'd0, 1'b1}},
    '{20'h55555,   1'b1, '{20'd0, 1'b1}}
  };

  stim_row_t shape_rows[] = '{
    '{20'd0,       1'b1, '{20'd0, 1'b0}},
    '{20'd5,       1'b0, '{20'd0, 1'b0}},
    '{20'd23,      1'b0, '{20'd0, 1'b0}},
    '{20'd24,      1'b1, '{20'd0, 1'b1}},
    '{20'hAAAAA,   1'b1, '{20'd0, 1'b1}},
    '{20'd13,      1'b0, '{20'd0, 1'b0}}
  };

  initial begin
    logic [10:0] ext [4];
    int unsigned phase_items;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_DIM_COUNT;
    cfg_data_i    = '0;
    error_count   = 0;
    sender_done   = 1'b0;
    dim_count_q   = 3'd4;
    for (int i = 0; i < REG_DIMS; i++) extent_q[i] = 11'd1;
    axis_order_q  = 8'd228;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_index(directed_rows[i].src, directed_rows[i].known,
                                          directed_rows[i].res);

    // A 2x3x4 tensor transposed to axes 2,0,1.
    configure_tensor(3'd3, 11'd2, 11'd3, 11'd4, 11'd7, 8'b00_01_00_10);
    foreach (shape_rows[i]) send_index(shape_rows[i].src, shape_rows[i].known,
                                       shape_rows[i].res);

    // Zero and saturated dimension counts, zero extents, unused and repeated axes.
    configure_tensor(3'd0, 11'd0, 11'd5, 11'd5, 11'd5, 8'b11_11_11_11);
    send_index(20'd0, 1'b0, '0);
    send_index(20'd1, 1'b1, '{20'd0, 1'b1});
    configure_tensor(3'd7, 11'd1024, 11'd1024, 11'd0, 11'd2047, 8'b00_00_01_01);
    send_index(20'hFFFFF, 1'b0, '0);
    send_index(20'h12345, 1'b0, '0);
    configure_tensor(3'd4, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 8'b00_01_10_11);
    send_index(20'hFFFFF, 1'b0, '0);
    send_index(20'd0, 1'b0, '0);
    configure_tensor(3'd2, 11'd1024, 11'd1024, 11'd1, 11'd1, 8'b11_10_00_01);
    send_index(20'hFFFFF, 1'b0, '0);
    send_index(20'd1025, 1'b0, '0);

    for (int phase = 0; phase < 14; phase++) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 4))
          0:       ext[i] = 11'($urandom_range(0, 2047));
          1:       ext[i] = 11'($urandom_range(1, 1024));
          default: ext[i] = 11'($urandom_range(1, 12));
        endcase
      end
      configure_tensor(($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4)),
                       ext[0], ext[1], ext[2], ext[3],
                       ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd27 ^ 8'($urandom_range(0, 3) * 85));
      phase_items = 50;
      for (int n = 0; n < phase_items; n++) send_index(random_index(), 1'b0, '0);
    end

    sender_done = 1'b1;
    drain_results();
    if (error_count == 0 && pending_indices.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: tensor_permute_index_map.f
rtl/core/tpim_pkg.sv
rtl/core/tpim_div_bit.sv
rtl/core/tpim_mac.sv
rtl/core/tensor_permute_index_map.sv
rtl/core/tpim_chk.sv
tb/tensor_permute_index_map_tb.sv
